>>> rtl/core/lfu_pkg.sv
`timescale 1ns / 1ps
package lfu_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned IDX_W = 8;   // index and rank width, covers up to 256 entries
  localparam int unsigned CNT_W = 9;   // occupancy, holds 256
  localparam int unsigned CAP_W = 5;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
  } rsp_t;

  // Scan token handed from cell to cell
  typedef struct packed {
    logic [31:0]      key;
    logic             found;
    logic [IDX_W-1:0] f_idx;
    logic [31:0]      f_value;
    logic [IDX_W-1:0] f_rank;
    logic             vic_found;
    logic [IDX_W-1:0] v_idx;
    logic [31:0]      v_count;
    logic [IDX_W-1:0] v_rank;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
  } tok_t;

  // Update broadcast to all cells
  typedef struct packed {
    logic             touch_en;
    logic             wr_value;
    logic [IDX_W-1:0] touch_idx;
    logic [IDX_W-1:0] touch_rank;
    logic             evict_en;
    logic [IDX_W-1:0] evict_idx;
    logic [IDX_W-1:0] evict_rank;
    logic             ins_en;
    logic [IDX_W-1:0] ins_idx;
    logic [31:0]      key;
    logic [31:0]      value;
  } cmd_t;

endpackage

>>> rtl/core/lfu_cell.sv
`timescale 1ns / 1ps
module lfu_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lfu_pkg::tok_t tok_i,
  output lfu_pkg::tok_t tok_o,
  input  lfu_pkg::cmd_t cmd_i
);
  import lfu_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic             valid_q, valid_d;
  logic [31:0]      key_q, key_d;
  logic [31:0]      value_q, value_d;
  logic [31:0]      count_q, count_d;
  logic [IDX_W-1:0] rank_q, rank_d;
  tok_t             tok_q, tok_d;

  always_comb begin
    tok_d = tok_i;
    if (valid_q && key_q == tok_i.key && !tok_i.found) begin
      tok_d.found   = 1'b1;
      tok_d.f_idx   = MyIdx;
      tok_d.f_value = value_q;
      tok_d.f_rank  = rank_q;
    end
    if (valid_q && (!tok_i.vic_found || count_q < tok_i.v_count ||
        (count_q == tok_i.v_count && rank_q > tok_i.v_rank))) begin
      tok_d.vic_found = 1'b1;
      tok_d.v_idx     = MyIdx;
      tok_d.v_count   = count_q;
      tok_d.v_rank    = rank_q;
    end
    if (!valid_q && !tok_i.free_found) begin
      tok_d.free_found = 1'b1;
      tok_d.free_idx   = MyIdx;
    end
  end

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    count_d = count_q;
    rank_d  = rank_q;
    if (cmd_i.touch_en && valid_q) begin
      if (cmd_i.touch_idx == MyIdx) begin
        rank_d = '0;
        if (count_q != 32'hFFFF_FFFF) count_d = count_q + 32'd1;
        if (cmd_i.wr_value) value_d = cmd_i.value;
      end else if (rank_q < cmd_i.touch_rank) begin
        rank_d = rank_q + IDX_W'(1);
      end
    end else if (cmd_i.ins_en && cmd_i.ins_idx == MyIdx) begin
      valid_d = 1'b1;
      key_d   = cmd_i.key;
      value_d = cmd_i.value;
      count_d = 32'd1;
      rank_d  = '0;
    end else if (cmd_i.evict_en && cmd_i.evict_idx == MyIdx) begin
      valid_d = 1'b0;
    end else if (valid_q) begin
      rank_d = rank_q - IDX_W'(cmd_i.evict_en && rank_q > cmd_i.evict_rank)
                      + IDX_W'(cmd_i.ins_en);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
    count_q <= count_d;
    rank_q  <= rank_d;
    tok_q   <= tok_d;
  end

  assign tok_o = tok_q;

endmodule

>>> rtl/core/lfu_cache_lookup_update.sv
`timescale 1ns / 1ps
// A request is registered on accept; its scan token then walks the cell row one cell per cycle,
// and the apply state updates the cells and registers the result, waiting while the output stalls.
// No new request is accepted until the block returns to idle after the apply state.
// A new request is taken while the previous result still waits in the output register.
// Reset clears all entries, occupancy and control; capacity resets to 16.
module lfu_cache_lookup_update #(
  parameter int unsigned MAX_ENTRIES = lfu_pkg::MAX_ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  lfu_pkg::req_t              in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output lfu_pkg::rsp_t              out_rsp_o,
  input  logic                       cfg_we_i,
  input  logic [lfu_pkg::CAP_W-1:0]  cfg_wdata_i
);
  import lfu_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_APPLY = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [CAP_W-1:0] cap_q;
  logic [CNT_W-1:0] used_q, used_d;
  req_t             req_q;
  tok_t             init_q, init_d;
  rsp_t             rsp_q, rsp_d;
  logic             out_valid_q, out_valid_d;
  tok_t             tok [MAX_ENTRIES+1];
  cmd_t             cmd;
  tok_t             t;
  logic [CNT_W-1:0] cap_eff;
  logic             go, evict;

  assign tok[0] = init_q;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    lfu_cell #(.IDX(g)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok[g]),
      .tok_o (tok[g+1]),
      .cmd_i (cmd)
    );
  end

  assign t  = tok[MAX_ENTRIES];
  assign go = (state_q == ST_APPLY) && (!out_valid_q || !out_stall_i);

  always_comb begin
    init_d     = '0;
    init_d.key = in_req_i.key;
  end

  always_comb begin
    cap_eff = (CNT_W'(cap_q) > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : CNT_W'(cap_q);
    cmd            = '0;
    cmd.key        = req_q.key;
    cmd.value      = req_q.value;
    cmd.touch_idx  = t.f_idx;
    cmd.touch_rank = t.f_rank;
    cmd.evict_idx  = t.v_idx;
    cmd.evict_rank = t.v_rank;
    evict          = 1'b0;
    rsp_d.hit        = t.found;
    rsp_d.read_value = '0;
    if (req_q.func == FUNC_GET) begin
      cmd.touch_en = t.found;
      if (t.found) rsp_d.read_value = t.f_value;
    end else if (cap_eff != '0) begin
      if (t.found) begin
        cmd.touch_en = 1'b1;
        cmd.wr_value = 1'b1;
      end else begin
        evict        = (used_q >= cap_eff) && t.vic_found;
        cmd.evict_en = evict;
        cmd.ins_en   = evict || t.free_found;
        cmd.ins_idx  = (evict && (!t.free_found || t.v_idx < t.free_idx)) ?
                       t.v_idx : t.free_idx;
      end
    end
    used_d = used_q - CNT_W'(evict) + CNT_W'(cmd.ins_en);
    if (!go) begin
      cmd.touch_en = 1'b0;
      cmd.evict_en = 1'b0;
      cmd.ins_en   = 1'b0;
      used_d       = used_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cnt_d = cnt_q + IDX_W'(1);
        if (cnt_q == IDX_W'(MAX_ENTRIES - 1)) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (go) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      cap_q       <= CAP_W'(16);
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      req_q  <= in_req_i;
      init_q <= init_d;
    end
    if (go) rsp_q <= rsp_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule
